[src/cqf_pkg.sv]
// Package for the circular queue FIFO: item structs, operation and status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package cqf_pkg;

    // Operation codes carried in the input item
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Status codes carried in the result item
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned FILL_W = 7;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] pop_value;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
        logic signed [WORD_W-1:0] head_word;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch the accepted input item
        logic execute;    // apply the operation to pointers and store
        logic load_head;  // take the store read data as the new head word
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_read;  // the step moved the head onto a stored word
    } t_dp_stat;

endpackage

[src/cqf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cqf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/cqf_ctrl.sv]
// Controller state machine of the circular queue FIFO.
// Depends on cqf_pkg for the command and status structs.
module cqf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cqf_pkg::t_dp_cmd  o_cmd,
    input  cqf_pkg::t_dp_stat i_stat
);
    import cqf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.need_read ? S_LOAD : S_DONE;
            end
            S_LOAD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = (r_state == S_DONE);
    assign o_cmd.capture     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute     = (r_state == S_EXEC);
    assign o_cmd.load_head   = (r_state == S_LOAD);

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not start execution");

    a_load_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ($past(r_state) == S_EXEC))
        else $error("head load without preceding execute");

    a_read_only_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !i_stat.need_read) |=> (r_state == S_DONE))
        else $error("execute without read did not finish");

endmodule

[src/cqf_dp.sv]
// Datapath of the circular queue FIFO: pointers, cached head word, slot
// store and the result register. Depends on cqf_pkg and cqf_ram.
module cqf_dp #(
    parameter int unsigned SLOTS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cqf_pkg::t_in_item  i_item,
    input  cqf_pkg::t_dp_cmd   i_cmd,
    output cqf_pkg::t_dp_stat  o_stat,
    output cqf_pkg::t_out_item o_item
);
    import cqf_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS);

    logic [1:0]        r_op;
    logic [WORD_W-1:0] r_val;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     n_head;
    logic [AW-1:0]     r_tail;
    logic [AW-1:0]     n_tail;
    logic [WORD_W-1:0] r_hw;     // word at head, valid while not empty
    logic [WORD_W-1:0] n_hw;
    t_out_item         r_res;
    t_out_item         n_res;

    logic              was_empty;
    logic              is_full;
    logic [AW-1:0]     tail_inc;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     fill_raw;
    logic [AW+FILL_W-1:0] fill_ext;
    logic              now_empty;
    logic              ram_we;
    logic              need_read;
    logic [WORD_W-1:0] rd_data;
    logic [1:0]        st;
    logic [WORD_W-1:0] popped;

    assign tail_inc  = r_tail + 1'b1;
    assign head_inc  = r_head + 1'b1;
    assign was_empty = (r_head == r_tail);
    assign is_full   = (tail_inc == r_head);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_hw      = r_hw;
        st        = ST_OK;
        popped    = '0;
        ram_we    = 1'b0;
        need_read = 1'b0;
        case (r_op)
            OP_ENQUEUE: begin
                if (is_full) begin
                    st = ST_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_tail = tail_inc;
                    if (was_empty) begin
                        n_hw = r_val;
                    end
                end
            end
            OP_DEQUEUE: begin
                if (was_empty) begin
                    st = ST_EMPTY;
                end else begin
                    popped    = r_hw;
                    n_head    = head_inc;
                    need_read = (head_inc != r_tail);
                end
            end
            OP_CLEAR: begin
                n_head = '0;
                n_tail = '0;
            end
            default: begin
                // unused selector: report the queue unchanged
            end
        endcase
    end

    assign now_empty = (n_head == n_tail);
    assign fill_raw  = n_tail - n_head;
    assign fill_ext  = {{FILL_W{1'b0}}, fill_raw};

    always_comb begin
        n_res            = r_res;
        n_res.status     = st;
        n_res.pop_value  = popped;
        n_res.fill_count = fill_ext[FILL_W-1:0];
        n_res.is_empty   = now_empty;
        n_res.head_word  = now_empty ? '0 : n_hw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cmd.execute) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_item.operation;
            r_val <= i_item.push_value;
        end
        if (i_cmd.execute) begin
            r_hw  <= n_hw;
            r_res <= n_res;
        end else if (i_cmd.load_head) begin
            r_hw            <= rd_data;
            r_res.head_word <= rd_data;
        end
    end

    cqf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we && i_cmd.execute),
        .i_waddr (r_tail),
        .i_wdata (r_val),
        .i_raddr (head_inc),
        .o_rdata (rd_data)
    );

    assign o_stat.need_read = need_read && i_cmd.execute;
    assign o_item           = r_res;

    a_enq_advances_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && r_op == OP_ENQUEUE && !is_full)
        |=> (r_tail == $past(tail_inc)))
        else $error("enqueue did not advance tail");

    a_full_keeps_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && r_op == OP_ENQUEUE && is_full)
        |=> ($stable(r_tail) && $stable(r_head)))
        else $error("refused enqueue moved a pointer");

    a_deq_never_overtakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && r_op == OP_DEQUEUE && was_empty) |=> $stable(r_head))
        else $error("dequeue on empty queue moved head");

endmodule

[src/circular_queue_fifo_unit.sv]
// Top level of the circular queue FIFO: controller plus datapath.
// Depends on cqf_pkg, cqf_ctrl, cqf_dp (and cqf_ram below it).
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_ready     i_in_item  (t_in_item)
//   result    out        o_out_valid / i_out_ready   o_out_item (t_out_item)
//
// One item is in flight at a time. The result is valid once the item has
// been executed, or after a further head load for a dequeue that leaves words
// behind: the new head word then comes through the store's registered read
// port. The next item is taken in the cycle after its result is delivered.
// Reset (synchronous, active low) empties the queue; store contents are
// not cleared and are never read before written. A stalled result holds.
module circular_queue_fifo_unit #(
    parameter int unsigned SLOTS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cqf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cqf_pkg::t_out_item o_out_item
);
    import cqf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence the item: capture, execute, optional head load, deliver
    cqf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Hold pointers, the cached head word, the slot store and the result
    cqf_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_item  (o_out_item)
    );

    a_one_side_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_refused_pop_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK) |-> (o_out_item.pop_value == '0))
        else $error("refused item carries a popped word");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_empty) |-> (o_out_item.head_word == '0))
        else $error("empty queue reports a head word");

endmodule

[tb/circular_queue_fifo_unit_test.sv]
// Testbench for circular_queue_fifo_unit: directed and random enqueue, dequeue,
// clear and unused-selector items against a mirror of the ring buffer.
// Depends on cqf_pkg and circular_queue_fifo_unit.
`timescale 1ns / 100ps

package cqf_tb_pkg;
    import cqf_pkg::*;

    localparam int unsigned SLOTS = 128;
    localparam int unsigned IDX_W = $clog2(SLOTS);
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    class fifo_mirror;
        logic [WORD_W-1:0] slot_word [SLOTS];
        logic [IDX_W-1:0]  head_ptr;
        logic [IDX_W-1:0]  tail_ptr;
        t_out_item         awaited_results [$];
        int unsigned       mismatch_count;

        function new();
            head_ptr = '0;
            tail_ptr = '0;
            mismatch_count = 0;
        endfunction

        // Apply one accepted item to the mirror and queue its result.
        function void note_request(t_in_item item);
            t_out_item        res;
            logic [IDX_W-1:0] next_tail;
            logic [IDX_W-1:0] span;
            res = '0;
            res.status = ST_OK;
            case (item.operation)
                OP_ENQUEUE: begin
                    next_tail = tail_ptr + 1'b1;
                    if (next_tail == head_ptr) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_word[tail_ptr] = item.push_value;
                        tail_ptr = next_tail;
                    end
                end
                OP_DEQUEUE: begin
                    if (head_ptr == tail_ptr) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.pop_value = slot_word[head_ptr];
                        head_ptr = head_ptr + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    head_ptr = '0;
                    tail_ptr = '0;
                end
                default: ;
            endcase
            span = tail_ptr - head_ptr;
            res.fill_count = FILL_W'(span);
            res.is_empty = (head_ptr == tail_ptr);
            res.head_word = res.is_empty ? '0 : slot_word[head_ptr];
            awaited_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        // Match one delivered result against the oldest queued one.
        function void check_response(t_out_item got);
            t_out_item want;
            if (awaited_results.size() == 0) begin
                $error("result with no pending item: %p", got);
                mismatch_count++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("pop_value", want.pop_value, got.pop_value);
            compare_field("fill_count", want.fill_count, got.fill_count);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("head_word", want.head_word, got.head_word);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass
endpackage

module circular_queue_fifo_unit_test;
    import cqf_pkg::*;
    import cqf_tb_pkg::*;

    // Random part size, the idle-free tail of it, and the watchdog limit
    localparam int RANDOM_ITEMS = 1780;
    localparam int CALM_ITEMS   = 300;
    localparam int QUIET_LIMIT  = 1000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    fifo_mirror mirror;
    bit         idle_enabled = 1'b1;

    circular_queue_fifo_unit #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one item and hold it until the block takes it. A random gap may
    // come first; valid drops only there, so back-to-back items keep it high
    // and each step sees a single assignment to it.
    task automatic send_request(input logic [1:0] op, input logic [WORD_W-1:0] word);
        t_in_item item;
        item.operation = op;
        item.push_value = word;
        if (idle_enabled && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        mirror.note_request(item);
    endtask

    // Favor the corner words now and then; otherwise take any 32-bit value.
    function automatic logic [WORD_W-1:0] random_word();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Pick an operation with the given enqueue and clear weights (percent);
    // the unused selector shows up at a small fixed rate.
    function automatic logic [1:0] pick_operation(int enqueue_pct, int clear_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_UNUSED;
        if (roll < 2 + clear_pct)
            return OP_CLEAR;
        return ($urandom_range(0, 99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE;
    endfunction

    // Result side: alternate ready bursts with stall bursts, and hold ready
    // high once idling is switched off.
    initial begin : result_side
        int burst;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (idle_enabled && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                burst = $urandom_range(1, 12);
            end else begin
                i_out_ready <= 1'b1;
                burst = $urandom_range(1, 24);
            end
            repeat (burst) @(posedge i_clk);
        end
    end

    // Check every result at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && i_out_ready)
            mirror.check_response(o_out_item);
    end

    // Abort when neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("circular_queue_fifo_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int span;
        int enqueue_pct;
        int clear_pct;
        mirror = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Refuse a dequeue, ignore the unused selector and clear, all on empty.
        send_request(OP_DEQUEUE, 32'h1234_5678);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        send_request(OP_CLEAR, 32'h0000_0000);
        // Store the extreme words and both bit checkerboards.
        send_request(OP_ENQUEUE, 32'h8000_0000);
        send_request(OP_ENQUEUE, 32'h7FFF_FFFF);
        send_request(OP_ENQUEUE, 32'h0000_0000);
        send_request(OP_ENQUEUE, 32'hFFFF_FFFF);
        send_request(OP_ENQUEUE, 32'h5555_5555);
        send_request(OP_ENQUEUE, 32'hAAAA_AAAA);
        // Unused selector on a non-empty queue must leave it as it is.
        send_request(OP_UNUSED, 32'hDEAD_BEEF);
        // Pop a few, then clear with words still stored.
        send_request(OP_DEQUEUE, 32'hFFFF_FFFF);
        send_request(OP_DEQUEUE, 32'h0000_0000);
        send_request(OP_DEQUEUE, 32'hA5A5_A5A5);
        send_request(OP_CLEAR, 32'hFFFF_FFFF);
        send_request(OP_DEQUEUE, 32'h0000_0001);
        // Refill over the stale slots, drain to empty, and refuse once more.
        send_request(OP_ENQUEUE, 32'h0000_0001);
        send_request(OP_ENQUEUE, 32'hFFFF_FFFE);
        send_request(OP_DEQUEUE, 32'h0000_0000);
        send_request(OP_DEQUEUE, 32'h0000_0000);
        send_request(OP_DEQUEUE, 32'h0000_0000);

        // Random phases: fill runs reach the full case and wrap the pointers,
        // drain runs reach empty, mixed runs sprinkle clears.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    enqueue_pct = 90;
                    clear_pct = 0;
                    span = $urandom_range(150, 300);
                end
                4, 5, 6: begin
                    enqueue_pct = 15;
                    clear_pct = 0;
                    span = $urandom_range(60, 200);
                end
                default: begin
                    enqueue_pct = 50;
                    clear_pct = 3;
                    span = $urandom_range(40, 160);
                end
            endcase
            for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
                if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                    idle_enabled = 1'b0;
                send_request(pick_operation(enqueue_pct, clear_pct), random_word());
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then leave time for strays.
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mirror.mismatch_count == 0 && mirror.pending() == 0)
            $display("circular_queue_fifo_unit regression: pass");
        else
            $display("circular_queue_fifo_unit regression: fail");
        $finish;
    end
endmodule
